@@ sv/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, status codes and the character classifier of the Base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int Q_DEPTH = 2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_PAD  = 2'd2;
    localparam logic [1:0] ST_BAD_LEN  = 2'd3;

    localparam logic [1:0] POS_LAST = 2'd3;
    localparam logic [1:0] POS_PAD  = 2'd2;

    typedef enum logic [1:0] {
        CLS_DATA,
        CLS_PAD,
        CLS_BAD
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [5:0]  val;
    } sextet_t;

    // One classified character as it travels from front to back
    typedef struct packed {
        sextet_t sx;
        logic    last;
    } entry_t;

    function automatic sextet_t classify(logic [7:0] c);
        sextet_t s;
        s.cls = CLS_DATA;
        s.val = '0;
        case (c) inside
            [8'h41:8'h5A]: s.val = 6'(c - 8'h41);
            [8'h61:8'h7A]: s.val = 6'(c - 8'h47);
            [8'h30:8'h39]: s.val = 6'(c + 8'h04);
            8'h2B:         s.val = 6'd62;
            8'h2F:         s.val = 6'd63;
            8'h3D:         s.cls = CLS_PAD;
            default:       s.cls = CLS_BAD;
        endcase
        return s;
    endfunction

endpackage

@@ sv/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Input stage: takes one character per transfer, classifies it against the
// alphabet and holds the result for the queue.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_in,
    input  logic       is_last,
    input  logic       in_valid,
    output logic       in_ready,
    output entry_t     push_entry,
    output logic       push_valid,
    input  logic       push_ready
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            entry_reg.sx   <= classify(char_in);
            entry_reg.last <= is_last;
        end
    end

endmodule

@@ sv/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_queue
// Short register queue between the classifier and the decode stage.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  entry_t push_entry,
    input  logic   push_valid,
    output logic   push_ready,
    output entry_t pop_entry,
    output logic   pop_valid,
    input  logic   pop_ready
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    entry_t             slots_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ sv/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Decode stage: group position, leftover bits, pad and error tracking, and
// the output register.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     pop_entry,
    input  logic       pop_valid,
    output logic       pop_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       end_of_string,
    output logic [1:0] status,
    output logic       out_valid,
    input  logic       out_ready
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [5:0] left_reg;
    logic [5:0] left_next;
    logic       pad_reg;
    logic       pad_next;
    logic [1:0] err_reg;
    logic [1:0] err_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       bvalid_reg;
    logic       bvalid_next;
    logic       eos_reg;
    logic       eos_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;

    logic       do_pop;
    logic       have_byte;
    logic [7:0] byte_val;
    logic [1:0] err;
    logic [1:0] st;
    logic       emit;

    assign pop_ready     = !out_valid_reg || out_ready;
    assign do_pop        = pop_valid && pop_ready;
    assign out_valid     = out_valid_reg;
    assign data_byte     = data_reg;
    assign byte_valid    = bvalid_reg;
    assign end_of_string = eos_reg;
    assign status        = status_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        left_next      = left_reg;
        pad_next       = pad_reg;
        err_next       = err_reg;
        have_byte      = 1'b0;
        byte_val       = '0;
        err            = err_reg;
        st             = ST_OK;
        emit           = 1'b0;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        data_next      = data_reg;
        bvalid_next    = bvalid_reg;
        eos_next       = eos_reg;
        status_next    = status_reg;

        if (do_pop)
        begin
            if (err_reg == ST_OK)
            begin
                if (pad_reg)
                begin
                    if (!(pop_entry.sx.cls == CLS_PAD && pop_entry.last))
                    begin
                        err = ST_BAD_PAD;
                    end
                end
                else
                begin
                    case (pop_entry.sx.cls)
                        CLS_BAD:
                        begin
                            err = ST_BAD_CHAR;
                        end
                        CLS_PAD:
                        begin
                            if (pos_reg == POS_PAD)
                            begin
                                if (!pop_entry.last)
                                begin
                                    pad_next = 1'b1;
                                end
                            end
                            else if (!(pos_reg == POS_LAST && pop_entry.last))
                            begin
                                err = ST_BAD_PAD;
                            end
                        end
                        default:
                        begin
                            case (pos_reg)
                                2'd0:
                                begin
                                    left_next = pop_entry.sx.val;
                                end
                                2'd1:
                                begin
                                    byte_val  = {left_reg, pop_entry.sx.val[5:4]};
                                    left_next = {2'b00, pop_entry.sx.val[3:0]};
                                    have_byte = 1'b1;
                                end
                                2'd2:
                                begin
                                    byte_val  = {left_reg[3:0], pop_entry.sx.val[5:2]};
                                    left_next = {4'b0000, pop_entry.sx.val[1:0]};
                                    have_byte = 1'b1;
                                end
                                default:
                                begin
                                    byte_val  = {left_reg[1:0], pop_entry.sx.val};
                                    left_next = '0;
                                    have_byte = 1'b1;
                                end
                            endcase
                        end
                    endcase
                end
                err_next = err;
            end

            if (pop_entry.last)
            begin
                st = (pos_reg != POS_LAST) ? ST_BAD_LEN : err;
                emit        = 1'b1;
                data_next   = (st == ST_OK) ? byte_val : 8'h00;
                bvalid_next = (st == ST_OK) && have_byte;
                eos_next    = 1'b1;
                status_next = st;
                pos_next    = '0;
                left_next   = '0;
                pad_next    = 1'b0;
                err_next    = ST_OK;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (err == ST_OK && have_byte)
                begin
                    emit        = 1'b1;
                    data_next   = byte_val;
                    bvalid_next = 1'b1;
                    eos_next    = 1'b0;
                    status_next = ST_OK;
                end
            end

            if (emit)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            left_reg      <= '0;
            pad_reg       <= 1'b0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            left_reg      <= left_next;
            pad_reg       <= pad_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        bvalid_reg <= bvalid_next;
        eos_reg    <= eos_next;
        status_reg <= status_next;
    end

    // Errors only surface on the final character, which carries no byte
    a_err_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (eos_reg && !bvalid_reg))
        else $error("b64d_back: error status outside end of string");

    // State returns to reset once the final character has been decoded
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && pop_entry.last) |=>
            (pos_reg == 2'd0 && err_reg == ST_OK && !pad_reg && left_reg == 6'd0))
        else $error("b64d_back: state not cleared after last character");

    // With no error recorded, a pending pad only sits at the fourth slot
    a_pad_position: assert property (@(posedge clk) disable iff (!rst_n)
        (pad_reg && err_reg == ST_OK) |-> (pos_reg == POS_LAST))
        else $error("b64d_back: pending pad at wrong group position");

endmodule

@@ sv/base64_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming Base64 decoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// One character enters per transfer and the block sustains one character per
// clock while out_ready is high; a decoded byte leaves as soon as its eight
// bits are known, i.e. at the second, third and fourth character of each
// group. A character passes the classifier register, the two-entry queue
// and the output register; the decode step ahead of the output register
// updates group position, leftover bits and error state. Errors are held
// until the character flagged last; that result carries end_of_string and a
// nonzero status, and the consumer should drop the bytes of that string.
// Characters after an error give no result until the last one.
module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_in,
    input  logic       is_last,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       end_of_string,
    output logic [1:0] status,
    output logic       out_valid,
    input  logic       out_ready
);

    entry_t push_entry;
    logic   push_valid;
    logic   push_ready;
    entry_t pop_entry;
    logic   pop_valid;
    logic   pop_ready;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .is_last    (is_last),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    b64d_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_entry     (pop_entry),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .end_of_string (end_of_string),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

endmodule

@@ tb/tb_base64_stream_decoder_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_unit
// Self-checking bench for the streaming Base64 decoder. A checker class keeps
// its own decode state, predicts the result of every character transfer and
// compares each output transfer field by field. Stimulus is a few hand-picked
// strings, then random strings: mostly well-formed, some corrupted, some of
// bad length, some pure byte noise. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_unit
    import b64d_pkg::*;
;

    localparam int N_CHARS    = 1400;
    localparam int SETTLE_CYC = 8;

    typedef struct {
        logic [7:0] data;
        logic       bv;
        logic       eos;
        logic [1:0] st;
    } b64_result_t;

    // ------------------------------------------------------------------------
    // Decode state mirror and result checking
    // ------------------------------------------------------------------------
    class b64_result_checker;
        logic [1:0]  grp_pos;
        logic [5:0]  left_bits;
        logic        pad_wait;
        logic [1:0]  err_code;
        b64_result_t pending_results[$];
        int          errors;

        function new();
            grp_pos   = '0;
            left_bits = '0;
            pad_wait  = 1'b0;
            err_code  = ST_OK;
            errors    = 0;
        endfunction

        function sextet_t char_to_sextet(logic [7:0] c);
            sextet_t s;
            s.cls = CLS_DATA;
            s.val = '0;
            if (c >= "A" && c <= "Z")      s.val = 6'(c - "A");
            else if (c >= "a" && c <= "z") s.val = 6'(c - "a" + 26);
            else if (c >= "0" && c <= "9") s.val = 6'(c - "0" + 52);
            else if (c == "+")             s.val = 6'd62;
            else if (c == "/")             s.val = 6'd63;
            else if (c == "=")             s.cls = CLS_PAD;
            else                           s.cls = CLS_BAD;
            return s;
        endfunction

        function void note_char(logic [7:0] c, logic is_final);
            sextet_t     sx;
            logic [1:0]  pos;
            logic [1:0]  err;
            logic        have;
            logic [7:0]  dbyte;
            b64_result_t r;
            sx    = char_to_sextet(c);
            pos   = grp_pos;
            err   = err_code;
            have  = 1'b0;
            dbyte = '0;
            if (err == ST_OK) begin
                if (pad_wait) begin
                    if (!(sx.cls == CLS_PAD && is_final))
                        err = ST_BAD_PAD;
                end else if (sx.cls == CLS_BAD) begin
                    err = ST_BAD_CHAR;
                end else if (sx.cls == CLS_PAD) begin
                    if (pos == POS_PAD) begin
                        if (!is_final)
                            pad_wait = 1'b1;
                    end else if (!(pos == POS_LAST && is_final)) begin
                        err = ST_BAD_PAD;
                    end
                end else begin
                    case (pos)
                        2'd0:
                        begin
                            left_bits = sx.val;
                        end
                        2'd1:
                        begin
                            dbyte     = {left_bits, sx.val[5:4]};
                            left_bits = {2'b00, sx.val[3:0]};
                            have      = 1'b1;
                        end
                        2'd2:
                        begin
                            dbyte     = {left_bits[3:0], sx.val[5:2]};
                            left_bits = {4'b0000, sx.val[1:0]};
                            have      = 1'b1;
                        end
                        default:
                        begin
                            dbyte     = {left_bits[1:0], sx.val};
                            left_bits = '0;
                            have      = 1'b1;
                        end
                    endcase
                end
                err_code = err;
            end

            if (is_final) begin
                r.st = (pos != POS_LAST) ? ST_BAD_LEN : err;
                if (r.st != ST_OK) begin
                    have  = 1'b0;
                    dbyte = '0;
                end
                r.data = dbyte;
                r.bv   = have;
                r.eos  = 1'b1;
                pending_results.insert(pending_results.size(), r);
                grp_pos   = '0;
                left_bits = '0;
                pad_wait  = 1'b0;
                err_code  = ST_OK;
            end else begin
                grp_pos = pos + 2'd1;
                if (err == ST_OK && have) begin
                    r.data = dbyte;
                    r.bv   = 1'b1;
                    r.eos  = 1'b0;
                    r.st   = ST_OK;
                    pending_results.insert(pending_results.size(), r);
                end
            end
        endfunction

        function void check_result(logic [7:0] data, logic bv, logic eos, logic [1:0] st);
            b64_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result data %02h valid %0d eos %0d status %0d",
                         $time, data, bv, eos, st);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (data !== e.data) begin
                $display("%0t: data_byte exp %02h got %02h", $time, e.data, data);
                errors++;
            end
            if (bv !== e.bv) begin
                $display("%0t: byte_valid exp %0d got %0d", $time, e.bv, bv);
                errors++;
            end
            if (eos !== e.eos) begin
                $display("%0t: end_of_string exp %0d got %0d", $time, e.eos, eos);
                errors++;
            end
            if (st !== e.st) begin
                $display("%0t: status exp %0d got %0d", $time, e.st, st);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic [7:0] char_in       = '0;
    logic       is_last       = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic [1:0] status;
    logic       out_valid;
    logic       out_ready     = 1'b0;

    b64_result_checker chk = new();

    logic       idle_on = 1'b1;
    int         sent    = 0;
    logic [7:0] str_q[$];

    base64_stream_decoder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_in       (char_in),
        .is_last       (is_last),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .end_of_string (end_of_string),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    // Sink side stalls
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= !idle_on || ($urandom_range(0, 99) >= 16);
    end

    // Observe both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                chk.note_char(char_in, is_last);
            if (out_valid && out_ready)
                chk.check_result(data_byte, byte_valid, end_of_string, status);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] sextet_char(int idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        if (idx == 62) return "+";
        return "/";
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_char(logic [7:0] c, logic fin);
        if (idle_on && $urandom_range(0, 99) < 16) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        is_last  <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_str();
        for (int i = 0; i < str_q.size(); i++)
            send_char(str_q[i], i == str_q.size() - 1);
    endtask

    task automatic send_text(string s);
        str_q.delete();
        for (int i = 0; i < s.len(); i++)
            str_q.insert(str_q.size(), s[i]);
        send_str();
    endtask

    // Sender holds off until every predicted result has been seen
    task automatic drain();
        in_valid <= 1'b0;
        while (chk.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic make_random_string();
        int kind;
        int ngroups;
        int npad;
        int idx;
        str_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            repeat ($urandom_range(1, 8))
                str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
        end else begin
            ngroups = $urandom_range(1, 4);
            repeat (ngroups * 4)
                str_q.insert(str_q.size(), sextet_char($urandom_range(0, 63)));
            npad = $urandom_range(0, 2);
            for (int i = 0; i < npad; i++)
                str_q[str_q.size() - 1 - i] = "=";
            if (kind >= 70 && kind < 88) begin
                // one character replaced by noise or a stray pad
                idx = $urandom_range(0, str_q.size() - 1);
                if ($urandom_range(0, 1))
                    str_q[idx] = 8'($urandom_range(0, 255));
                else
                    str_q[idx] = "=";
            end else if (kind >= 88) begin
                if ($urandom_range(0, 1) && str_q.size() > 1)
                    str_q.pop_back();
                else
                    repeat ($urandom_range(1, 3))
                        str_q.insert(str_q.size(), sextet_char($urandom_range(0, 63)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        send_text("A/+z");
        send_text("QQ==");
        send_text("QUJ=");           // nonzero unused bits before the pad
        str_q.delete();
        str_q.insert(str_q.size(), "Q");
        str_q.insert(str_q.size(), "U");
        str_q.insert(str_q.size(), 8'hFF);      // invalid character
        str_q.insert(str_q.size(), 8'h00);
        send_str();
        send_text("=AAA");           // pad at group start
        send_text("QU=");            // pad at third position as last
        send_text("QU=A");           // data after a pending pad
        send_text("A");              // too short

        while (sent < N_CHARS) begin
            idle_on = !(sent >= 500 && sent < 800);
            if (sent >= 1000 && sent < 1020)
                drain();
            make_random_string();
            send_str();
        end
        idle_on = 1'b1;
        drain();

        if (chk.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ base64_stream_decoder_unit.f @@
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder_unit.sv
tb/tb_base64_stream_decoder_unit.sv
